>>> hw/rtl/eas_pkg.sv
package eas_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int COUNT_BITS_DEF    = 16;

	localparam int FS_W    = 17;
	localparam int PP_W    = 7;
	localparam int SCALE_W = 32;
	localparam int CFG_W   = 32;
	localparam int VAR_W   = 32;
	localparam int ANG_W   = 16;
	localparam int SPD_W   = 32;
	localparam int D_W     = 18;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [2:0] {
		FUNC_MEASURE    = 3'd0,
		FUNC_RESEED     = 3'd1,
		FUNC_CAL_CLEAR  = 3'd2,
		FUNC_CAL_SAMPLE = 3'd3,
		FUNC_CAL_FINISH = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		REG_FULL_SCALE  = 2'd0,
		REG_POLE_PAIRS  = 2'd1,
		REG_ANGLE_SCALE = 2'd2,
		REG_SPEED_SCALE = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_ANG,
		ST_M_ELA,
		ST_M_SPD,
		ST_M_DPP,
		ST_M_ESP,
		ST_M_END,
		ST_SAMPLE,
		ST_FILL,
		ST_C_SUM,
		ST_C_DIVS,
		ST_C_WAITS,
		ST_C_SQ,
		ST_C_DIVQ,
		ST_C_WAITQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] encoder_count;
	} in_t;

	typedef struct packed {
		logic [ANG_W-1:0]        mech_angle;
		logic [ANG_W-1:0]        elec_angle;
		logic signed [SPD_W-1:0] mech_speed;
		logic signed [SPD_W-1:0] elec_speed;
		logic [15:0]             zero_offset;
		logic [VAR_W-1:0]        noise_variance;
	} out_t;

	typedef struct packed {
		logic fill;
		logic wr;
		logic rd;
	} ring_ctl_t;

	function automatic logic signed [SPD_W-1:0] sat32(input logic signed [MUL_P_W-1:0] p);
		logic signed [MUL_P_W-1:0] hi;
		logic signed [MUL_P_W-1:0] lo;
		hi = {{(MUL_P_W-SPD_W+1){1'b0}}, {(SPD_W-1){1'b1}}};
		lo = {{(MUL_P_W-SPD_W+1){1'b1}}, {(SPD_W-1){1'b0}}};
		if (p > hi) begin
			sat32 = {1'b0, {(SPD_W-1){1'b1}}};
		end else if (p < lo) begin
			sat32 = {1'b1, {(SPD_W-1){1'b0}}};
		end else begin
			sat32 = $signed(p[SPD_W-1:0]);
		end
	endfunction

endpackage

>>> hw/rtl/encoder_angle_speed_estimator_core.sv
// Encoder angle and speed estimator. Each input beat carries an operation code and a raw
// count and yields exactly one output beat. A measure beat steps through the angle,
// electrical angle, speed, pole-pair speed, electrical speed and end states; reseed
// and calibration clear pass through a fill state, calibration sample through a sample
// state, an unknown code straight to done. Calibration finish walks the history ring twice
// through its single read port and runs two divisions by the depth as reciprocal
// multiplications, 16 dividend bits a cycle. A new beat is taken only while idle.
// Angle, speed and squared-deviation products share one registered multiplier that the
// sequencer steps through in turn.
// The history ring resets through per-entry valid bits, so no clearing pass follows reset.
// Configuration writes take effect at once and must only arrive while the block is idle.
module encoder_angle_speed_estimator_core #(
	parameter int HISTORY_DEPTH = eas_pkg::HISTORY_DEPTH_DEF,
	parameter int COUNT_BITS    = eas_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  eas_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output eas_pkg::out_t             out_data,
	input  logic                      cfg_wr_en,
	input  eas_pkg::cfg_reg_t         cfg_index,
	input  logic [eas_pkg::CFG_W-1:0] cfg_data
);

	import eas_pkg::*;

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int CW    = $clog2(HISTORY_DEPTH + 2);
	localparam int ACC_W = 2 * COUNT_BITS + $clog2(HISTORY_DEPTH);
	localparam int E_W   = COUNT_BITS + 1;

	logic [FS_W-1:0]    full_scale_q;
	logic [PP_W-1:0]    pole_pairs_q;
	logic [SCALE_W-1:0] angle_scale_q;
	logic [SCALE_W-1:0] speed_scale_q;

	state_t state_q;
	state_t state_d;

	logic [2:0]               func_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic [COUNT_BITS-1:0]    pos_q;
	logic signed [D_W-1:0]    d_q;
	logic [AW-1:0]            idx_q;
	logic [CW-1:0]            cnt_q;
	logic                     rdv_q;
	logic                     pv_q;
	logic [ACC_W-1:0]         acc_q;
	logic [COUNT_BITS-1:0]    zero_q;
	logic [VAR_W-1:0]         var_q;
	logic [ANG_W-1:0]         mech_angle_q;
	logic [ANG_W-1:0]         elec_angle_q;
	logic signed [SPD_W-1:0]  mech_speed_q;
	logic signed [SPD_W-1:0]  elec_speed_q;
	logic                     out_valid_q;
	out_t                     out_q;

	ring_ctl_t                ring_ctl;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic [COUNT_BITS-1:0]    wr_data;
	logic [COUNT_BITS-1:0]    fill_value;
	logic [COUNT_BITS-1:0]    ring_rd;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_s1;
	logic                     div_start;
	logic                     div_done;
	logic [ACC_W-1:0]         div_quot;

	logic                     in_accept;
	logic                     out_load;
	logic [COUNT_BITS-1:0]    count_in;
	logic [AW-1:0]            idx_next;
	logic                     cnt_lt;
	logic signed [D_W-1:0]    d_raw;
	logic signed [D_W-1:0]    d_fold;
	logic signed [D_W-1:0]    fs_s;
	logic signed [D_W-1:0]    half_s;
	logic signed [E_W-1:0]    e_val;

	eas_ring #(
		.DEPTH (HISTORY_DEPTH),
		.W     (COUNT_BITS)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.fill_value (fill_value),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (ring_rd)
	);

	eas_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	eas_div #(
		.DIVISOR (HISTORY_DEPTH),
		.W       (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign count_in  = in_data.encoder_count[COUNT_BITS-1:0];
	assign idx_next  = (idx_q == AW'(HISTORY_DEPTH - 1)) ? '0 : idx_q + AW'(1);
	assign cnt_lt    = cnt_q < CW'(HISTORY_DEPTH);
	assign d_raw     = $signed(D_W'(pos_q)) - $signed(D_W'(ring_rd));
	assign fs_s      = $signed(D_W'(full_scale_q));
	assign half_s    = $signed(D_W'(full_scale_q[FS_W-1:1]));
	assign e_val     = $signed(E_W'(ring_rd)) - $signed(E_W'(zero_q));

	always_comb begin
		d_fold = d_raw;
		priority if (d_raw > 0 && d_raw >= half_s) begin
			d_fold = d_raw - fs_s;
		end else if (d_raw < 0 && d_raw <= -half_s) begin
			d_fold = d_raw + fs_s;
		end else begin
			d_fold = d_raw;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					unique case (in_data.func)
						FUNC_MEASURE:    state_d = ST_M_ANG;
						FUNC_RESEED:     state_d = ST_FILL;
						FUNC_CAL_CLEAR:  state_d = ST_FILL;
						FUNC_CAL_SAMPLE: state_d = ST_SAMPLE;
						FUNC_CAL_FINISH: state_d = ST_C_SUM;
						default:         state_d = ST_DONE;
					endcase
				end
			end
			ST_M_ANG:   state_d = ST_M_ELA;
			ST_M_ELA:   state_d = ST_M_SPD;
			ST_M_SPD:   state_d = ST_M_DPP;
			ST_M_DPP:   state_d = ST_M_ESP;
			ST_M_ESP:   state_d = ST_M_END;
			ST_M_END:   state_d = ST_DONE;
			ST_SAMPLE:  state_d = ST_DONE;
			ST_FILL:    state_d = ST_DONE;
			ST_C_SUM: begin
				if (cnt_q == CW'(HISTORY_DEPTH)) begin
					state_d = ST_C_DIVS;
				end
			end
			ST_C_DIVS:  state_d = ST_C_WAITS;
			ST_C_WAITS: begin
				if (div_done) begin
					state_d = ST_C_SQ;
				end
			end
			ST_C_SQ: begin
				if (cnt_q == CW'(HISTORY_DEPTH + 1)) begin
					state_d = ST_C_DIVQ;
				end
			end
			ST_C_DIVQ:  state_d = ST_C_WAITQ;
			ST_C_WAITQ: begin
				if (div_done) begin
					state_d = ST_FILL;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		ring_ctl   = '0;
		rd_addr    = idx_q;
		wr_addr    = idx_q;
		wr_data    = pos_q;
		fill_value = '0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				ring_ctl.rd = 1'b1;
			end
			ST_M_ANG: begin
				ring_ctl.wr = 1'b1;
				mul_a       = $signed(MUL_A_W'(angle_scale_q));
				mul_b       = $signed(MUL_B_W'(pos_q));
			end
			ST_M_ELA: begin
				mul_a = $signed(MUL_A_W'(prod_s1[31:0]));
				mul_b = $signed(MUL_B_W'(pole_pairs_q));
			end
			ST_M_SPD: begin
				mul_a = $signed(MUL_A_W'(speed_scale_q));
				mul_b = MUL_B_W'(d_q);
			end
			ST_M_DPP: begin
				mul_a = $signed(MUL_A_W'(pole_pairs_q));
				mul_b = MUL_B_W'(d_q);
			end
			ST_M_ESP: begin
				mul_a = $signed(MUL_A_W'(speed_scale_q));
				mul_b = $signed(prod_s1[MUL_B_W-1:0]);
			end
			ST_SAMPLE: begin
				ring_ctl.wr = 1'b1;
				wr_data     = count_q;
			end
			ST_FILL: begin
				ring_ctl.fill = 1'b1;
				fill_value    = (func_q == FUNC_CAL_CLEAR) ? '0 : count_q - zero_q;
			end
			ST_C_SUM: begin
				rd_addr     = cnt_q[AW-1:0];
				ring_ctl.rd = cnt_lt;
			end
			ST_C_DIVS: div_start = 1'b1;
			ST_C_SQ: begin
				rd_addr     = cnt_q[AW-1:0];
				ring_ctl.rd = cnt_lt;
				mul_a       = MUL_A_W'(e_val);
				mul_b       = MUL_B_W'(e_val);
			end
			ST_C_DIVQ: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			full_scale_q  <= FS_W'(16384);
			pole_pairs_q  <= PP_W'(1);
			angle_scale_q <= SCALE_W'(262144);
			speed_scale_q <= '0;
			idx_q         <= '0;
			cnt_q         <= '0;
			rdv_q         <= 1'b0;
			pv_q          <= 1'b0;
			zero_q        <= '0;
			var_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_FULL_SCALE:  full_scale_q  <= cfg_data[FS_W-1:0];
					REG_POLE_PAIRS:  pole_pairs_q  <= cfg_data[PP_W-1:0];
					REG_ANGLE_SCALE: angle_scale_q <= cfg_data[SCALE_W-1:0];
					REG_SPEED_SCALE: speed_scale_q <= cfg_data[SCALE_W-1:0];
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						cnt_q <= '0;
						rdv_q <= 1'b0;
						pv_q  <= 1'b0;
					end
				end
				ST_M_ANG:  idx_q <= idx_next;
				ST_SAMPLE: idx_q <= idx_next;
				ST_FILL:   idx_q <= '0;
				ST_C_SUM: begin
					cnt_q <= cnt_q + CW'(1);
					rdv_q <= cnt_lt;
				end
				ST_C_WAITS: begin
					if (div_done) begin
						zero_q <= div_quot[COUNT_BITS-1:0];
						cnt_q  <= '0;
						rdv_q  <= 1'b0;
						pv_q   <= 1'b0;
					end
				end
				ST_C_SQ: begin
					cnt_q <= cnt_q + CW'(1);
					rdv_q <= cnt_lt;
					pv_q  <= rdv_q;
				end
				ST_C_WAITQ: begin
					if (div_done) begin
						var_q <= VAR_W'(div_quot);
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					func_q       <= in_data.func;
					count_q      <= count_in;
					pos_q        <= count_in - zero_q;
					acc_q        <= '0;
					mech_angle_q <= '0;
					elec_angle_q <= '0;
					mech_speed_q <= '0;
					elec_speed_q <= '0;
				end
			end
			ST_M_ANG: d_q          <= d_fold;
			ST_M_ELA: mech_angle_q <= prod_s1[31:16];
			ST_M_SPD: elec_angle_q <= prod_s1[31:16];
			ST_M_DPP: mech_speed_q <= sat32(prod_s1);
			ST_M_END: elec_speed_q <= sat32(prod_s1);
			ST_C_SUM: begin
				if (rdv_q) begin
					acc_q <= acc_q + ACC_W'(ring_rd);
				end
			end
			ST_C_WAITS: begin
				if (div_done) begin
					acc_q <= '0;
				end
			end
			ST_C_SQ: begin
				if (pv_q) begin
					acc_q <= acc_q + prod_s1[ACC_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.mech_angle     <= mech_angle_q;
			out_q.elec_angle     <= elec_angle_q;
			out_q.mech_speed     <= mech_speed_q;
			out_q.elec_speed     <= elec_speed_q;
			out_q.zero_offset    <= 16'(zero_q);
			out_q.noise_variance <= var_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_nonmeasure_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && func_q != FUNC_MEASURE) |->
		(mech_angle_q == '0 && elec_angle_q == '0 && mech_speed_q == '0 && elec_speed_q == '0))
		else $error("non-measure result carries angle or speed");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_C_WAITS || state_q == ST_C_WAITQ))
		else $error("divider finished while not awaited");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= AW'(HISTORY_DEPTH - 1))
		else $error("ring index beyond depth");

endmodule

>>> hw/rtl/eas_ring.sv
module eas_ring #(
	parameter int DEPTH = eas_pkg::HISTORY_DEPTH_DEF,
	parameter int W     = eas_pkg::COUNT_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eas_pkg::ring_ctl_t ctl,
	input  logic [W-1:0]       fill_value,
	input  logic [AW-1:0]      wr_addr,
	input  logic [W-1:0]       wr_data,
	input  logic [AW-1:0]      rd_addr,
	output logic [W-1:0]       rd_data
);

	logic [W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0]     fill_q;
	logic [W-1:0]     mem_rd_q;
	logic             hit_q;
	logic [W-1:0]     fill_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			mem_rd_q  <= mem[rd_addr];
			hit_q     <= valid_q[rd_addr];
			fill_rd_q <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (ctl.fill) begin
			valid_q <= '0;
			fill_q  <= fill_value;
		end else if (ctl.wr) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = hit_q ? mem_rd_q : fill_rd_q;

endmodule

>>> hw/rtl/eas_mul.sv
module eas_mul (
	input  logic                                 clk,
	input  logic signed [eas_pkg::MUL_A_W-1:0]   a,
	input  logic signed [eas_pkg::MUL_B_W-1:0]   b,
	output logic signed [eas_pkg::MUL_P_W-1:0]   prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

>>> hw/rtl/eas_div.sv
module eas_div #(
	parameter int DIVISOR = eas_pkg::HISTORY_DEPTH_DEF,
	parameter int W       = 2 * eas_pkg::COUNT_BITS_DEF + $clog2(eas_pkg::HISTORY_DEPTH_DEF)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int LW  = $clog2(DIVISOR);
	localparam int K   = W + LW;
	localparam int M_W = W + 1;
	localparam int DIG = 16;
	localparam int NCH = (W + DIG - 1) / DIG;
	localparam int XW  = NCH * DIG;
	localparam int PW  = XW + M_W + LW;
	localparam int CW  = $clog2(NCH + 1);

	localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << K) / 64'(DIVISOR)) + 64'd1);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [XW-1:0]      num_q;
	logic [PW-1:0]      acc_q;
	logic [DIG+M_W-1:0] part;

	assign part = (DIG+M_W)'(num_q[XW-1 -: DIG]) * (DIG+M_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			num_q <= XW'(dividend);
		end else if (busy_q) begin
			acc_q <= {acc_q[PW-DIG-1:0], {DIG{1'b0}}} + PW'(part);
			num_q <= {num_q[XW-DIG-1:0], {DIG{1'b0}}};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q[K +: W];

endmodule

>>> verif/tb_encoder_angle_speed_estimator_core.sv
`timescale 1ns / 100ps

module tb_encoder_angle_speed_estimator_core;

	import eas_pkg::*;

	localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam longint COUNT_MASK = (64'd1 << COUNT_BITS_DEF) - 1;
	localparam longint MASK32 = 64'h0000_0000_FFFF_FFFF;
	localparam int LONG_HOLD = 400;
	localparam int LIMIT_CYCLES = 800000;
	localparam int PRINT_CAP = 100;

	localparam logic [2:0] FUNC_RSVD_A = 3'd5;
	localparam logic [2:0] FUNC_RSVD_B = 3'd6;
	localparam logic [2:0] FUNC_RSVD_C = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_wr_en = 1'b0;
	cfg_reg_t cfg_index = REG_FULL_SCALE;
	logic [CFG_W-1:0] cfg_data = '0;

	// shadow of the estimator state and its registers
	longint hist_ring [HIST_DEPTH];
	int ring_at;
	longint zero_pt;
	longint noise_var;
	longint fs_reg, pp_reg, as_reg, ss_reg;

	in_t sample_beats [$];
	out_t estimates_due [$];

	int fail_count = 0;
	int cycle_count = 0;
	int tx_gap, tx_quiet;
	int rx_hold, rx_quiet;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;

	encoder_angle_speed_estimator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic void fill_ring(input longint v);
		for (int i = 0; i < HIST_DEPTH; i++)
			hist_ring[i] = v;
		ring_at = 0;
	endfunction

	function automatic void reset_shadow();
		fs_reg = 16384;
		pp_reg = 1;
		as_reg = 262144;
		ss_reg = 0;
		zero_pt = 0;
		noise_var = 0;
		fill_ring(0);
	endfunction

	task automatic estimate_beat(input in_t b);
		out_t r;
		longint pos, d, half, frac, efrac, sp, sum, sq, e;
		r = '0;
		pos = b.encoder_count;
		case (b.func)
		FUNC_MEASURE: begin
			pos = (pos - zero_pt) & COUNT_MASK;
			d = pos - hist_ring[ring_at];
			half = fs_reg >> 1;
			if (d > 0 && d >= half)
				d = d - fs_reg;
			else if (d < 0 && d <= -half)
				d = d + fs_reg;
			hist_ring[ring_at] = pos;
			ring_at = (ring_at + 1) % HIST_DEPTH;
			frac = (pos * as_reg) & MASK32;
			efrac = (frac * pp_reg) & MASK32;
			r.mech_angle = frac[31:16];
			r.elec_angle = efrac[31:16];
			sp = d * ss_reg;
			r.mech_speed = clamp32(sp);
			r.elec_speed = clamp32(sp * pp_reg);
		end
		FUNC_RESEED:
			fill_ring((pos - zero_pt) & COUNT_MASK);
		FUNC_CAL_CLEAR:
			fill_ring(0);
		FUNC_CAL_SAMPLE: begin
			hist_ring[ring_at] = pos & COUNT_MASK;
			ring_at = (ring_at + 1) % HIST_DEPTH;
		end
		FUNC_CAL_FINISH: begin
			sum = 0;
			for (int i = 0; i < HIST_DEPTH; i++)
				sum += hist_ring[i];
			zero_pt = (sum / HIST_DEPTH) & COUNT_MASK;
			sq = 0;
			for (int i = 0; i < HIST_DEPTH; i++) begin
				e = hist_ring[i] - zero_pt;
				sq += e * e;
			end
			noise_var = (sq / HIST_DEPTH) & MASK32;
			fill_ring((pos - zero_pt) & COUNT_MASK);
		end
		default: ;
		endcase
		r.zero_offset = zero_pt[15:0];
		r.noise_variance = noise_var[31:0];
		estimates_due.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic compare_estimate(input out_t got);
		out_t want;
		if (estimates_due.size() == 0) begin
			report_mismatch("beat with no result pending", got.mech_angle, '0);
			return;
		end
		want = estimates_due.pop_front();
		if (got.mech_angle !== want.mech_angle)
			report_mismatch("mech_angle", got.mech_angle, want.mech_angle);
		if (got.elec_angle !== want.elec_angle)
			report_mismatch("elec_angle", got.elec_angle, want.elec_angle);
		if (got.mech_speed !== want.mech_speed)
			report_mismatch("mech_speed", got.mech_speed, want.mech_speed);
		if (got.elec_speed !== want.elec_speed)
			report_mismatch("elec_speed", got.elec_speed, want.elec_speed);
		if (got.zero_offset !== want.zero_offset)
			report_mismatch("zero_offset", got.zero_offset, want.zero_offset);
		if (got.noise_variance !== want.noise_variance)
			report_mismatch("noise_variance", got.noise_variance, want.noise_variance);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
			tx_quiet = 0;
		end else begin
			if (in_valid && !in_stall)
				estimate_beat(in_data);
			if (!(in_valid && in_stall)) begin
				if (tx_gap != 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (sample_beats.size() != 0) begin
					in_data <= sample_beats.pop_front();
					in_valid <= 1'b1;
					tx_gap = pick_gap(tx_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
			rx_quiet = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_estimate(out_data);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else begin
				rx_hold = pick_gap(rx_quiet);
				out_stall <= (rx_hold != 0);
			end
		end
	end

	task automatic queue_beat(input logic [2:0] f, input int c);
		in_t b;
		b.func = f;
		b.encoder_count = c[15:0];
		sample_beats.push_back(b);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input longint val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[31:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
		REG_FULL_SCALE: fs_reg = val & 64'h1FFFF;
		REG_POLE_PAIRS: pp_reg = val & 64'h7F;
		REG_ANGLE_SCALE: as_reg = val & MASK32;
		REG_SPEED_SCALE: ss_reg = val & MASK32;
		endcase
	endtask

	task automatic set_config(input longint fs, input longint pp, input longint as,
			input longint ss);
		write_reg(REG_FULL_SCALE, fs);
		write_reg(REG_POLE_PAIRS, pp);
		write_reg(REG_ANGLE_SCALE, as);
		write_reg(REG_SPEED_SCALE, ss);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_beats.size() != 0 || in_valid || estimates_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// mostly rotating-shaft runs and calibration sequences, with some noise
	task automatic queue_random(input int n);
		int left, kind, vel, len, centre, ang;
		left = n;
		ang = $urandom_range(0, 65535);
		@(negedge clk);
		while (left > 0) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				if ($urandom_range(0, 99) < 30) begin
					queue_beat(FUNC_RESEED, ang);
					left--;
				end
				if ($urandom_range(0, 99) < 80)
					vel = int'($urandom_range(0, 600)) - 300;
				else
					vel = int'($urandom_range(0, 65535)) - 32768;
				len = $urandom_range(4, 20);
				repeat (len) begin
					ang = ang + vel + int'($urandom_range(0, 8)) - 4;
					queue_beat(FUNC_MEASURE, ang);
					left--;
				end
			end else if (kind < 72) begin
				centre = $urandom_range(0, 65535);
				queue_beat(FUNC_CAL_CLEAR, $urandom);
				repeat (HIST_DEPTH)
					queue_beat(FUNC_CAL_SAMPLE, centre + int'($urandom_range(0, 64)) - 32);
				queue_beat(FUNC_CAL_FINISH, $urandom);
				left -= HIST_DEPTH + 2;
			end else if (kind < 80) begin
				queue_beat(FUNC_RESEED, $urandom);
				left--;
			end else begin
				queue_beat(3'($urandom), $urandom);
				left--;
			end
		end
	endtask

	initial begin
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		set_config(16384, 3, 262144, 32'h0001_2345);
		@(negedge clk);
		queue_beat(FUNC_CAL_CLEAR, 0);
		queue_beat(FUNC_MEASURE, 0);
		queue_beat(FUNC_MEASURE, 16'hFFFF);
		queue_beat(FUNC_RESEED, 16'h1000);
		queue_beat(FUNC_MEASURE, 16'h1000 + 8192);
		queue_beat(FUNC_MEASURE, 16'h1000 - 8192);
		queue_beat(FUNC_MEASURE, 16'h1000 + 8191);
		queue_beat(FUNC_MEASURE, 16'h1000 - 8191);
		queue_beat(FUNC_RSVD_A, 16'hABCD);
		queue_beat(FUNC_RSVD_B, 16'h5432);
		queue_beat(FUNC_RSVD_C, 16'hFFFF);
		queue_beat(FUNC_CAL_SAMPLE, 16'hFFFF);
		queue_beat(FUNC_CAL_SAMPLE, 16'h0000);
		queue_beat(FUNC_CAL_SAMPLE, 16'h8000);
		queue_beat(FUNC_CAL_SAMPLE, 16'h7FFF);
		queue_beat(FUNC_CAL_SAMPLE, 16'h1234);
		queue_beat(FUNC_CAL_SAMPLE, 16'hFFFF);
		queue_beat(FUNC_CAL_SAMPLE, 16'h0001);
		queue_beat(FUNC_CAL_SAMPLE, 16'hFFFE);
		queue_beat(FUNC_CAL_FINISH, 16'h4321);
		queue_beat(FUNC_MEASURE, 16'h4321);
		queue_beat(FUNC_MEASURE, 16'h0000);
		wait_drained();

		set_config(65536, 64, 65536, 32'hFFFF_FFFF);
		queue_random(80);
		wait_drained();

		set_config(2, 1, 32'h8000_0000, 1);
		queue_random(80);
		wait_drained();

		// hold the result side so the block backs up onto its input
		set_config(1000, 7, 4294967, 32'h0000_4000);
		@(negedge clk);
		hold_req = ~hold_req;
		queue_random(80);
		wait_drained();

		set_config(1, 0, 32'hFFFF_FFFF, 32'h0003_0000);
		queue_random(80);
		wait_drained();

		set_config(131071, 127, 0, 32'h7FFF_FFFF);
		queue_random(80);
		wait_drained();

		set_config($urandom_range(2, 65536), $urandom_range(1, 64), $urandom, $urandom);
		queue_random(80);
		wait_drained();

		repeat (20) @(posedge clk);
		if (estimates_due.size() != 0)
			report_mismatch("results never delivered", estimates_due.size(), 0);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> encoder_angle_speed_estimator_core.f
hw/rtl/eas_pkg.sv
hw/rtl/eas_ring.sv
hw/rtl/eas_mul.sv
hw/rtl/eas_div.sv
hw/rtl/encoder_angle_speed_estimator_core.sv
verif/tb_encoder_angle_speed_estimator_core.sv
